@@ rtl/fba_pkg.sv @@
// Shared package for the free block bitmap allocator.
// Holds field widths, opcode and status codes, and the command and status structs
// that run between the controller and the datapath. Depends on nothing.
package fba_pkg;

    localparam int OPCODE_W  = 2;
    localparam int BLK_IDX_W = 14;
    localparam int LIMIT_W   = 15;
    localparam int STATUS_W  = 2;

    localparam logic [OPCODE_W-1:0] OP_TEST    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLAIM   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd10237;

    // Commands from the controller.
    typedef struct packed {
        logic clr_step;   // write zero to the next bitmap word and to the same-numbered summary word if it exists
        logic req_load;   // capture a new request word
        logic sum_rd;     // read the summary word under the scan pointer
        logic scan_take;  // take the first non-full bitmap word found in the summary
        logic scan_next;  // advance the scan pointer
        logic map_rd;     // read the selected bitmap word
        logic modify;     // evaluate the map word, write back unless test or no candidate, read its summary word
        logic sum_wr;     // write the updated summary word
        logic res_range;  // result: index out of range
        logic res_full;   // result: no free block
        logic out_load;   // move the result into the output register
    } t_dp_cmd;

    // Status from the datapath.
    typedef struct packed {
        logic clr_last;
        logic is_alloc;
        logic is_test;
        logic in_range;
        logic sum_has_free;
        logic base_in_lim;
        logic sidx_last;
        logic cand_ok;
    } t_dp_stat;

endpackage

@@ rtl/free_block_bitmap_allocator.sv @@
// Top level of the free block bitmap allocator.
// Instantiates fba_ctrl and fba_dpath and holds the port-level checks; depends on fba_pkg.
//
// Request words arrive on the input channel (i_in_valid / o_in_ready) with an opcode
// (test, release, claim, allocate) and a block index. Every request word produces one
// result word on the output channel (o_out_valid / i_out_ready): a free flag for test,
// the claimed block for allocate, and a status of ok, no free block or out of range.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes the block limit and is
// always ready; it should only be written while no request is in flight.
// An out-of-range request goes straight to its result word; a test reads the bitmap word,
// and a release or claim also writes it back and updates its summary word. Allocate scans
// a summary memory of per-word full flags one summary word at a time until it finds a
// word that is not full, then claims that word's first free block like a claim. The next
// request is taken in the cycle after the result word is loaded; one request is worked on
// at a time, and each memory has a single read port.
// After reset the block sweeps the bitmap to all free, one word per cycle, so it accepts
// no request until the sweep is done.
// When the receiver stalls, a finished result sits in the output register; the next
// request is accepted meanwhile and its result waits in the datapath until the output
// register has been taken.
module free_block_bitmap_allocator #(
    parameter int TOTAL_BLOCKS = 16384,
    parameter int WORD_BITS    = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fba_pkg::LIMIT_W-1:0]   i_cfg_block_limit,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [fba_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [fba_pkg::BLK_IDX_W-1:0] i_block_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_block_free,
    output logic [fba_pkg::BLK_IDX_W-1:0] o_allocated_index,
    output logic [fba_pkg::STATUS_W-1:0]  o_status
);
    import fba_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // The limit register can take a word in any cycle.
    assign o_cfg_ready = 1'b1;

    fba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fba_dpath #(
        .TOTAL_BLOCKS (TOTAL_BLOCKS),
        .WORD_BITS    (WORD_BITS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid && o_cfg_ready),
        .i_cfg_block_limit (i_cfg_block_limit),
        .i_opcode          (i_opcode),
        .i_block_index     (i_block_index),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_block_free      (o_block_free),
        .o_allocated_index (o_allocated_index),
        .o_status          (o_status)
    );

    // The clearing pass always follows reset, so no request is taken right after it.
    a_no_accept_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("request channel ready during the clearing pass");

    // A claimed block is only reported together with an ok status and no free flag.
    a_alloc_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_allocated_index != '0) |-> (o_status == ST_OK && !o_block_free))
        else $error("allocated block reported with a bad status or free flag");

    // A free flag is only reported for a test that was in range.
    a_free_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_block_free) |-> (o_status == ST_OK && o_allocated_index == '0))
        else $error("free flag reported with a bad status or block number");

    // A request channel that has just accepted a word drops ready while that request is worked on.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request channel ready while a request is being worked on");

endmodule

@@ rtl/fba_ctrl.sv @@
// Controller of the free block bitmap allocator.
// One-hot state machine that sequences clearing, lookups, summary scans and updates.
// Depends on fba_pkg for the command and status structs.
module fba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  fba_pkg::t_dp_stat i_stat,
    output fba_pkg::t_dp_cmd  o_cmd
);
    import fba_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_DEC   = 9'b000000100,
        S_SRD   = 9'b000001000,
        S_SCHK  = 9'b000010000,
        S_MRD   = 9'b000100000,
        S_MOD   = 9'b001000000,
        S_SUPD  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.req_load = 1'b1;
                    n_state        = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.is_alloc) begin
                    n_state = S_SRD;
                end else if (!i_stat.in_range) begin
                    o_cmd.res_range = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    n_state = S_MRD;
                end
            end
            S_SRD: begin
                o_cmd.sum_rd = 1'b1;
                n_state      = S_SCHK;
            end
            S_SCHK: begin
                if (i_stat.sum_has_free) begin
                    if (i_stat.base_in_lim) begin
                        o_cmd.scan_take = 1'b1;
                        n_state         = S_MRD;
                    end else begin
                        o_cmd.res_full = 1'b1;
                        n_state        = S_DONE;
                    end
                end else if (i_stat.sidx_last) begin
                    o_cmd.res_full = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_SRD;
                end
            end
            S_MRD: begin
                o_cmd.map_rd = 1'b1;
                n_state      = S_MOD;
            end
            S_MOD: begin
                o_cmd.modify = 1'b1;
                if (i_stat.is_test || (i_stat.is_alloc && !i_stat.cand_ok)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SUPD;
                end
            end
            S_SUPD: begin
                o_cmd.sum_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/fba_dpath.sv @@
// Datapath of the free block bitmap allocator.
// Holds the bitmap memory, the per-word full summary memory, the limit register and results.
// Depends on fba_pkg; driven by commands from fba_ctrl.
module fba_dpath #(
    parameter int TOTAL_BLOCKS = 16384,
    parameter int WORD_BITS    = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [fba_pkg::LIMIT_W-1:0]      i_cfg_block_limit,
    input  logic [fba_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [fba_pkg::BLK_IDX_W-1:0]    i_block_index,
    input  fba_pkg::t_dp_cmd                 i_cmd,
    output fba_pkg::t_dp_stat                o_stat,
    output logic                             o_block_free,
    output logic [fba_pkg::BLK_IDX_W-1:0]    o_allocated_index,
    output logic [fba_pkg::STATUS_W-1:0]     o_status
);
    import fba_pkg::*;

    localparam int WB_LOG    = $clog2(WORD_BITS);
    localparam int MAP_WORDS = (TOTAL_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int SUM_WORDS = (MAP_WORDS + WORD_BITS - 1) / WORD_BITS;
    localparam int MAP_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SUM_AW    = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
    localparam int BLK_W     = $clog2(TOTAL_BLOCKS);
    localparam int CMP_W     = (BLK_W + WB_LOG + 1 > LIMIT_W) ? (BLK_W + WB_LOG + 1) : LIMIT_W;

    // Lowest clear bit of a word; callers guarantee one exists.
    function automatic logic [WB_LOG-1:0] first_zero(input logic [WORD_BITS-1:0] w);
        logic [WB_LOG-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                pos = WB_LOG'(i);
            end
        end
        return pos;
    endfunction

    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] sum_mem [SUM_WORDS];

    logic [LIMIT_W-1:0]   r_block_limit;
    logic [OPCODE_W-1:0]  r_op;
    logic [BLK_IDX_W-1:0] r_blk;
    logic [MAP_AW-1:0]    r_word;
    logic [SUM_AW-1:0]    r_sidx;
    logic [MAP_AW-1:0]    r_clr_cnt;
    logic [WORD_BITS-1:0] r_map_q;
    logic [WORD_BITS-1:0] r_sum_q;
    logic                 r_full;
    logic                 r_res_free;
    logic [BLK_IDX_W-1:0] r_res_alloc;
    logic [STATUS_W-1:0]  r_res_status;
    logic                 r_out_free;
    logic [BLK_IDX_W-1:0] r_out_alloc;
    logic [STATUS_W-1:0]  r_out_status;

    logic [CMP_W-1:0]     lim_ext, total_ext, eff_lim, blk_ext, word_ext;
    logic [CMP_W-1:0]     found_word, cand_ext;
    logic [WB_LOG-1:0]    sum_zero_pos, map_zero_pos, bit_pos, sum_bit;
    logic [WORD_BITS-1:0] word0_mask, map_masked, bit_mask, map_new, sum_mask, sum_new;
    logic                 is_test, is_alloc, cand_ok, map_full;
    logic                 map_we, sum_we, sum_re;
    logic [MAP_AW-1:0]    map_waddr;
    logic [WORD_BITS-1:0] map_wdata, sum_wdata;
    logic [SUM_AW-1:0]    sum_waddr, sum_raddr, sum_addr_upd;
    logic [MAP_AW-1:0]    load_word;

    always_comb begin
        lim_ext   = CMP_W'(r_block_limit);
        total_ext = CMP_W'(TOTAL_BLOCKS);
        eff_lim   = (lim_ext > total_ext) ? total_ext : lim_ext;
        blk_ext   = CMP_W'(r_blk);
        word_ext  = CMP_W'(r_word);
        is_test   = (r_op == OP_TEST);
        is_alloc  = (r_op == OP_ALLOC);

        // Summary scan: the first word not marked full.
        sum_zero_pos = first_zero(r_sum_q);
        found_word   = (CMP_W'(r_sidx) << WB_LOG) | CMP_W'(sum_zero_pos);

        // Block zero is never allocated, so it counts as used in word zero.
        word0_mask   = (r_word == '0) ? WORD_BITS'(1) : '0;
        map_masked   = r_map_q | word0_mask;
        map_zero_pos = first_zero(map_masked);
        cand_ext     = (word_ext << WB_LOG) | CMP_W'(map_zero_pos);
        cand_ok      = (cand_ext < eff_lim);

        bit_pos  = is_alloc ? map_zero_pos : blk_ext[WB_LOG-1:0];
        bit_mask = WORD_BITS'(1) << bit_pos;
        map_new  = (r_op == OP_RELEASE) ? (r_map_q & ~bit_mask) : (r_map_q | bit_mask);
        map_full = &(map_new | word0_mask);

        sum_bit      = word_ext[WB_LOG-1:0];
        sum_addr_upd = SUM_AW'(word_ext >> WB_LOG);
        sum_mask     = WORD_BITS'(1) << sum_bit;
        sum_new      = r_full ? (r_sum_q | sum_mask) : (r_sum_q & ~sum_mask);

        load_word = MAP_AW'(CMP_W'(i_block_index) >> WB_LOG);

        map_we    = i_cmd.clr_step ||
                    (i_cmd.modify && !is_test && (!is_alloc || cand_ok));
        map_waddr = i_cmd.clr_step ? r_clr_cnt : r_word;
        map_wdata = i_cmd.clr_step ? '0 : map_new;

        sum_we    = (i_cmd.clr_step && (CMP_W'(r_clr_cnt) < CMP_W'(SUM_WORDS))) ||
                    i_cmd.sum_wr;
        sum_waddr = i_cmd.clr_step ? SUM_AW'(r_clr_cnt) : sum_addr_upd;
        sum_wdata = i_cmd.clr_step ? '0 : sum_new;
        sum_re    = i_cmd.sum_rd || i_cmd.modify;
        sum_raddr = i_cmd.sum_rd ? r_sidx : sum_addr_upd;

        o_stat.clr_last     = (r_clr_cnt == MAP_AW'(MAP_WORDS - 1));
        o_stat.is_alloc     = is_alloc;
        o_stat.is_test      = is_test;
        o_stat.in_range     = (blk_ext < eff_lim);
        o_stat.sum_has_free = ~&r_sum_q;
        o_stat.base_in_lim  = ((found_word << WB_LOG) < eff_lim);
        o_stat.sidx_last    = (r_sidx == SUM_AW'(SUM_WORDS - 1));
        o_stat.cand_ok      = cand_ok;
    end

    // Memories with registered read data.
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (i_cmd.map_rd) begin
            r_map_q <= map_mem[r_word];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        if (sum_re) begin
            r_sum_q <= sum_mem[sum_raddr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_limit <= LIMIT_RESET;
            r_clr_cnt     <= '0;
            r_sidx        <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_block_limit <= i_cfg_block_limit;
            end
            if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + MAP_AW'(1);
            end
            if (i_cmd.req_load) begin
                r_sidx <= '0;
            end else if (i_cmd.scan_next) begin
                r_sidx <= r_sidx + SUM_AW'(1);
            end
        end
    end

    // Request and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_op         <= i_opcode;
            r_blk        <= i_block_index;
            r_word       <= load_word;
            r_res_free   <= 1'b0;
            r_res_alloc  <= '0;
            r_res_status <= ST_OK;
        end
        if (i_cmd.scan_take) begin
            r_word <= MAP_AW'(found_word);
        end
        if (i_cmd.res_range) begin
            r_res_status <= ST_RANGE;
        end
        if (i_cmd.res_full) begin
            r_res_status <= ST_FULL;
        end
        if (i_cmd.modify) begin
            r_full <= map_full;
            if (is_test) begin
                r_res_free <= ~r_map_q[bit_pos];
            end
            if (is_alloc) begin
                if (cand_ok) begin
                    r_res_alloc <= BLK_IDX_W'(cand_ext);
                end else begin
                    r_res_status <= ST_FULL;
                end
            end
        end
        if (i_cmd.out_load) begin
            r_out_free   <= r_res_free;
            r_out_alloc  <= r_res_alloc;
            r_out_status <= r_res_status;
        end
    end

    assign o_block_free      = r_out_free;
    assign o_allocated_index = r_out_alloc;
    assign o_status          = r_out_status;

endmodule

@@ dv/free_block_bitmap_allocator_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for free_block_bitmap_allocator: a bitmap tracker predicts every reply
// word, and tasks drive directed and random request words under varying back-pressure.
// Depends on fba_pkg and the free_block_bitmap_allocator RTL.
module free_block_bitmap_allocator_tb;

    import fba_pkg::*;

    localparam int TOTAL_BLOCKS = 16384;
    localparam int WORD_BITS    = 32;
    localparam int MAP_WORDS    = TOTAL_BLOCKS / WORD_BITS;
    localparam int ITEMS_PER_PHASE = 70;

    // One reply word as the block presents it on the output channel.
    typedef struct packed {
        logic                 block_free;
        logic [BLK_IDX_W-1:0] allocated_index;
        logic [STATUS_W-1:0]  status;
    } t_reply;

    // The tracker keeps its own copy of the used/free bitmap and of the block limit. Every
    // accepted request word updates that copy and queues the reply the block must give.
    class bitmap_tracker;
        logic [WORD_BITS-1:0] used_words [MAP_WORDS];
        logic [LIMIT_W-1:0]   block_limit;
        t_reply               expected_replies [$];
        int                   error_count;

        function new();
            foreach (used_words[w]) used_words[w] = '0;
            block_limit = LIMIT_RESET;
            error_count = 0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] value);
            block_limit = value;
        endfunction

        function int usable_limit();
            return (int'(block_limit) > TOTAL_BLOCKS) ? TOTAL_BLOCKS : int'(block_limit);
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        function void note_request(logic [OPCODE_W-1:0] op, logic [BLK_IDX_W-1:0] idx);
            t_reply r;
            int     lim;
            int     b;
            bit     found;
            lim   = usable_limit();
            r     = '{block_free: 1'b0, allocated_index: '0, status: ST_OK};
            found = 1'b0;
            if (op == OP_ALLOC) begin
                // First fit from block 1; block 0 is never handed out.
                r.status = ST_FULL;
                for (b = 1; b < lim && !found; b++) begin
                    if (!used_words[b / WORD_BITS][b % WORD_BITS]) begin
                        used_words[b / WORD_BITS][b % WORD_BITS] = 1'b1;
                        r.allocated_index = b[BLK_IDX_W-1:0];
                        r.status = ST_OK;
                        found = 1'b1;
                    end
                end
            end else if (int'(idx) >= lim) begin
                r.status = ST_RANGE;
            end else begin
                case (op)
                    OP_TEST: begin
                        r.block_free = !used_words[idx / WORD_BITS][idx % WORD_BITS];
                    end
                    OP_RELEASE: begin
                        used_words[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
                    end
                    default: begin
                        used_words[idx / WORD_BITS][idx % WORD_BITS] = 1'b1;
                    end
                endcase
            end
            expected_replies.push_back(r);
        endfunction

        function void check_reply(logic free_bit, logic [BLK_IDX_W-1:0] aidx,
                                  logic [STATUS_W-1:0] st);
            t_reply want;
            if (expected_replies.size() == 0) begin
                $error({"reply word with none expected: ",
                        "block_free %0d allocated_index %0d status %0d"},
                       free_bit, aidx, st);
                error_count++;
                return;
            end
            want = expected_replies.pop_front();
            if (free_bit !== want.block_free) begin
                $error("block_free mismatch: expected %0d, actual %0d", want.block_free, free_bit);
                error_count++;
            end
            if (aidx !== want.allocated_index) begin
                $error("allocated_index mismatch: expected %0d, actual %0d",
                       want.allocated_index, aidx);
                error_count++;
            end
            if (st !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, st);
                error_count++;
            end
        endfunction

        function void report_leftovers();
            if (expected_replies.size() != 0) begin
                $error("%0d expected reply words never arrived", expected_replies.size());
                error_count += expected_replies.size();
            end
        endfunction
    endclass

    // Every input starts at a known value; after time zero they only change at falling edges.
    logic                 i_clk             = 1'b0;
    logic                 i_rst_n           = 1'b0;
    logic                 i_cfg_valid       = 1'b0;
    logic [LIMIT_W-1:0]   i_cfg_block_limit = '0;
    logic                 i_in_valid        = 1'b0;
    logic [OPCODE_W-1:0]  i_opcode          = '0;
    logic [BLK_IDX_W-1:0] i_block_index     = '0;
    logic                 i_out_ready       = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_block_free;
    logic [BLK_IDX_W-1:0] o_allocated_index;
    logic [STATUS_W-1:0]  o_status;

    // Percentages of cycles in which the sender and the receiver hold back.
    int send_idle_pct = 27;
    int recv_idle_pct = 51;

    bitmap_tracker tracker = new();

    free_block_bitmap_allocator #(
        .TOTAL_BLOCKS(TOTAL_BLOCKS),
        .WORD_BITS   (WORD_BITS)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_block_limit(i_cfg_block_limit),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_block_index    (i_block_index),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_block_free     (o_block_free),
        .o_allocated_index(o_allocated_index),
        .o_status         (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver decides once per cycle, at the falling edge, whether it takes a reply word.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Reply words are sampled at the rising edge, where valid and ready are both settled.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.check_reply(o_block_free, o_allocated_index, o_status);
        end
    end

    // Presents one request word, possibly after a few idle cycles, and holds it until the block
    // takes it. The task is entered at a falling edge and leaves at the one after the word is taken.
    task automatic send_request(logic [OPCODE_W-1:0] op, logic [BLK_IDX_W-1:0] idx);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_block_index <= idx;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_request(op, idx);
        @(negedge i_clk);
    endtask

    // Drops valid and waits until every reply word in flight has been taken.
    task automatic drain_replies();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (tracker.pending() != 0) @(negedge i_clk);
    endtask

    // Writes the block limit. Only called with nothing in flight.
    task automatic write_limit(int value);
        i_cfg_valid       <= 1'b1;
        i_cfg_block_limit <= value[LIMIT_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_limit(value[LIMIT_W-1:0]);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One random phase: a new limit, then a mix weighted toward allocate and release so that
    // small limits fill up and free again. Most indices stay in range and near the low blocks
    // that allocate hands out; others span the usable range or the whole field, often out of range.
    task automatic run_phase(int limit_value, int send_pct, int recv_pct);
        int                   pick;
        int                   lim;
        int                   hi;
        logic [OPCODE_W-1:0]  op;
        logic [BLK_IDX_W-1:0] idx;
        drain_replies();
        write_limit(limit_value);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        lim = tracker.usable_limit();
        hi  = lim - 1;
        for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Halfway through, the sender holds off until every reply word has come back.
            if (n == ITEMS_PER_PHASE / 2) drain_replies();
            pick = $urandom_range(0, 99);
            if (pick < 40)      op = OP_ALLOC;
            else if (pick < 65) op = OP_RELEASE;
            else if (pick < 80) op = OP_CLAIM;
            else                op = OP_TEST;
            pick = $urandom_range(0, 99);
            if (hi < 0 || pick >= 80) begin
                idx = BLK_IDX_W'($urandom_range(0, TOTAL_BLOCKS - 1));
            end else if (pick < 55) begin
                idx = BLK_IDX_W'($urandom_range(0, (hi < 127) ? hi : 127));
            end else begin
                idx = BLK_IDX_W'($urandom_range(0, hi));
            end
            send_request(op, idx);
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset limit: block zero, redundant writes, the range edge and
        // an allocate whose ignored index field is all ones.
        send_request(OP_TEST, 14'd0);
        send_request(OP_CLAIM, 14'd0);
        send_request(OP_TEST, 14'd0);
        send_request(OP_ALLOC, 14'd0);
        send_request(OP_ALLOC, 14'd0);
        send_request(OP_RELEASE, 14'd1);
        send_request(OP_TEST, 14'd1);
        send_request(OP_ALLOC, 14'd0);
        send_request(OP_RELEASE, 14'd7);
        send_request(OP_CLAIM, 14'd2);
        send_request(OP_TEST, 14'd10236);
        send_request(OP_TEST, 14'd10237);
        send_request(OP_CLAIM, 14'd16383);
        send_request(OP_RELEASE, 14'd16383);
        send_request(OP_ALLOC, 14'd16383);

        // A limit of zero puts every index out of range and leaves allocate nothing to find.
        drain_replies();
        write_limit(0);
        send_request(OP_TEST, 14'd0);
        send_request(OP_ALLOC, 14'd0);

        // A limit of one still covers block zero, but allocate has no candidate.
        drain_replies();
        write_limit(1);
        send_request(OP_TEST, 14'd0);
        send_request(OP_ALLOC, 14'd0);

        // The all-ones limit acts as the full capacity, so the top block is reachable.
        drain_replies();
        write_limit(32767);
        send_request(OP_CLAIM, 14'd16383);
        send_request(OP_TEST, 14'd16383);
        send_request(OP_RELEASE, 14'd16383);
        send_request(OP_TEST, 14'd16383);

        // Random phases: sender sparse and receiver very slow, then the reverse, then no idling.
        run_phase(40, 27, 51);
        run_phase(16384, 27, 51);
        run_phase(2, 27, 51);
        run_phase(97, 51, 27);
        run_phase(32767, 51, 27);
        run_phase(33, 51, 27);
        run_phase(64, 0, 0);
        run_phase(10237, 0, 0);
        run_phase(200, 0, 0);

        drain_replies();
        // Allow for the longest allocate scan in case a stray reply word is still on its way.
        repeat (50) @(negedge i_clk);
        tracker.report_leftovers();
        if (tracker.error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run, including the bitmap sweep after reset.
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
